>>> design/assert_macros.svh
// Assertion helpers; both expect signals named clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds at every clock edge outside reset.
`define PDES_ASSERT_NOW(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed");

// Consequence that must hold in the cycle after the antecedent.
`define PDES_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> design/pdes_pkg.sv
`default_nettype none
package pdes_pkg;

   localparam int CSR_AW    = 5;
   localparam int SQ_STAGES = 16;

   localparam logic [2:0] REG_STEP_TIME   = 3'd0;
   localparam logic [2:0] REG_GRAVITY_Y   = 3'd1;
   localparam logic [2:0] REG_VIEW_AXIS_X = 3'd2;
   localparam logic [2:0] REG_VIEW_AXIS_Y = 3'd3;
   localparam logic [2:0] REG_VIEW_AXIS_Z = 3'd4;

   localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
   localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

   typedef struct packed {
      logic signed [31:0] position_x;
      logic signed [31:0] position_y;
      logic signed [31:0] position_z;
      logic signed [31:0] velocity_x;
      logic signed [31:0] velocity_y;
      logic signed [31:0] velocity_z;
      logic [23:0]        drag_factor;
      logic signed [31:0] life_left;
      logic [23:0]        fade_rate;
      logic               alive;
      logic [3:0]         frame_index;
      logic               advance_frame;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_position_x;
      logic signed [31:0] new_position_y;
      logic signed [31:0] new_position_z;
      logic signed [31:0] new_velocity_x;
      logic signed [31:0] new_velocity_y;
      logic signed [31:0] new_velocity_z;
      logic signed [31:0] new_life;
      logic               still_alive;
      logic [3:0]         new_frame_index;
      logic signed [31:0] view_depth;
   } rsp_type;

   typedef struct packed {
      logic [16:0]        step_time;
      logic signed [31:0] gravity_y;
      logic signed [17:0] view_axis_x;
      logic signed [17:0] view_axis_y;
      logic signed [17:0] view_axis_z;
   } cfg_type;

   typedef struct packed {
      req_type          rec;
      logic [2:0][31:0] mag;
   } work_type;

   localparam cfg_type CFG_RESET = '{
      step_time:   17'd0,
      gravity_y:   -32'sd13107,
      view_axis_x: 18'sd0,
      view_axis_y: 18'sd0,
      view_axis_z: 18'sd65536
   };

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      if (x > SAT_MAX) begin
         sat32 = 32'sh7fffffff;
      end else if (x < SAT_MIN) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = x[31:0];
      end
   endfunction

endpackage
`default_nettype wire

>>> design/pdes_if.sv
`default_nettype none
interface pdes_req_if;
   import pdes_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface pdes_rsp_if;
   import pdes_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/pdes_csr.sv
`default_nettype none
module pdes_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [pdes_pkg::CSR_AW-1:0]  paddr,
   input  wire logic [31:0]                  pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready,
   output pdes_pkg::cfg_type                 cfg
);
   import pdes_pkg::*;

   cfg_type    cfg_ff;
   logic [2:0] idx;
   logic       wr;

   assign idx    = paddr[CSR_AW-1:2];
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (wr) begin
         case (idx)
            REG_STEP_TIME:   cfg_ff.step_time   <= pwdata[16:0];
            REG_GRAVITY_Y:   cfg_ff.gravity_y   <= pwdata;
            REG_VIEW_AXIS_X: cfg_ff.view_axis_x <= pwdata[17:0];
            REG_VIEW_AXIS_Y: cfg_ff.view_axis_y <= pwdata[17:0];
            REG_VIEW_AXIS_Z: cfg_ff.view_axis_z <= pwdata[17:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_STEP_TIME:   prdata = {15'd0, cfg_ff.step_time};
         REG_GRAVITY_Y:   prdata = cfg_ff.gravity_y;
         REG_VIEW_AXIS_X: prdata = {14'd0, cfg_ff.view_axis_x};
         REG_VIEW_AXIS_Y: prdata = {14'd0, cfg_ff.view_axis_y};
         REG_VIEW_AXIS_Z: prdata = {14'd0, cfg_ff.view_axis_z};
         default:         prdata = 32'd0;
      endcase
   end
endmodule
`default_nettype wire

>>> design/pdes_front.sv
`default_nettype none
module pdes_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_vld,
   input  pdes_pkg::req_type       in_rec,
   output logic                    in_rdy,
   output logic                    out_vld,
   output pdes_pkg::work_type      out_work,
   output logic [63:0]             out_sumsq,
   input  wire logic               out_rdy
);
   import pdes_pkg::*;

   logic [2:1]       vld_ff;
   logic [3:1]       en;
   work_type         work1_ff;
   work_type         work2_ff;
   logic [63:0]      sq1_ff [3];
   logic [63:0]      sum2_ff;
   logic [2:0][31:0] mag_in;

   function automatic logic [31:0] abs32(input logic signed [31:0] v);
      abs32 = v[31] ? unsigned'(-v) : unsigned'(v);
   endfunction

   assign mag_in[0] = abs32(in_rec.velocity_x);
   assign mag_in[1] = abs32(in_rec.velocity_y);
   assign mag_in[2] = abs32(in_rec.velocity_z);

   assign en[3]  = out_rdy;
   assign en[2]  = !vld_ff[2] || en[3];
   assign en[1]  = !vld_ff[1] || en[2];
   assign in_rdy = en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[1]) vld_ff[1] <= in_vld;
         if (en[2]) vld_ff[2] <= vld_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         work1_ff.rec <= in_rec;
         work1_ff.mag <= mag_in;
         for (int i = 0; i < 3; i++) sq1_ff[i] <= mag_in[i] * mag_in[i];
      end
      if (en[2]) begin
         work2_ff <= work1_ff;
         sum2_ff  <= sq1_ff[0] + sq1_ff[1] + sq1_ff[2];
      end
   end

   assign out_vld   = vld_ff[2];
   assign out_work  = work2_ff;
   assign out_sumsq = sum2_ff;
endmodule
`default_nettype wire

>>> design/pdes_sqrt.sv
`default_nettype none
module pdes_sqrt (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_vld,
   input  pdes_pkg::work_type      in_work,
   input  wire logic [63:0]        in_rad,
   output logic                    in_rdy,
   output logic                    out_vld,
   output pdes_pkg::work_type      out_work,
   output logic [31:0]             out_root,
   input  wire logic               out_rdy
);
   import pdes_pkg::*;

   logic [SQ_STAGES-1:0] vld_ff;
   logic [SQ_STAGES:0]   en;
   work_type             work_ff [SQ_STAGES];
   logic [63:0]          rad_ff  [SQ_STAGES];
   logic [33:0]          rem_ff  [SQ_STAGES];
   logic [31:0]          root_ff [SQ_STAGES];

   // one restoring square-root digit: {remainder, root}
   function automatic logic [65:0] root_step(input logic [33:0] rem,
                                             input logic [31:0] q,
                                             input logic [1:0] pair);
      logic [33:0] r;
      logic [33:0] trial;
      r     = {rem[31:0], pair};
      trial = {q, 2'b01};
      if (r >= trial) begin
         root_step = {34'(r - trial), q[30:0], 1'b1};
      end else begin
         root_step = {r, q[30:0], 1'b0};
      end
   endfunction

   assign en[SQ_STAGES] = out_rdy;
   assign in_rdy        = en[0];

   for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
      logic        src_vld;
      work_type    src_work;
      logic [63:0] src_rad;
      logic [33:0] src_rem;
      logic [31:0] src_root;
      logic [65:0] mid;
      logic [65:0] fin;

      if (s == 0) begin : g_first
         assign src_vld  = in_vld;
         assign src_work = in_work;
         assign src_rad  = in_rad;
         assign src_rem  = '0;
         assign src_root = '0;
      end else begin : g_next
         assign src_vld  = vld_ff[s-1];
         assign src_work = work_ff[s-1];
         assign src_rad  = rad_ff[s-1];
         assign src_rem  = rem_ff[s-1];
         assign src_root = root_ff[s-1];
      end

      assign mid   = root_step(src_rem, src_root, src_rad[63:62]);
      assign fin   = root_step(mid[65:32], mid[31:0], src_rad[61:60]);
      assign en[s] = !vld_ff[s] || en[s+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en[s]) begin
            vld_ff[s] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            work_ff[s] <= src_work;
            rad_ff[s]  <= {src_rad[59:0], 4'd0};
            rem_ff[s]  <= fin[65:32];
            root_ff[s] <= fin[31:0];
         end
      end
   end

   assign out_vld  = vld_ff[SQ_STAGES-1];
   assign out_work = work_ff[SQ_STAGES-1];
   assign out_root = root_ff[SQ_STAGES-1];
endmodule
`default_nettype wire

>>> design/pdes_back.sv
`default_nettype none
module pdes_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_vld,
   input  pdes_pkg::work_type      in_work,
   input  wire logic [31:0]        in_speed,
   output logic                    in_rdy,
   input  pdes_pkg::cfg_type       cfg,
   output logic                    out_vld,
   output pdes_pkg::rsp_type       out_rsp,
   input  wire logic               out_rdy
);
   import pdes_pkg::*;

   logic [9:1]         vld_ff;
   logic [10:1]        en;

   work_type           w1_ff;
   logic [63:0]        prod1_ff [3];
   logic [40:0]        dec1_ff;
   req_type            rec_ff [2:7];
   logic signed [31:0] nl_ff [2:7];
   logic [47:0]        hi2_ff [3];
   logic [47:0]        lo2_ff [3];
   logic signed [31:0] acc3_ff [3];
   logic signed [49:0] adt4_ff [3];
   logic signed [31:0] nv_ff [5:8][3];
   logic signed [49:0] vdt6_ff [3];
   logic signed [31:0] np_ff [7:8][3];
   logic signed [49:0] dp8_ff [3];
   logic signed [31:0] life8_ff;
   logic               live8_ff;
   logic [3:0]         frame8_ff;
   rsp_type            rsp9_ff;

   logic signed [17:0] dts;
   logic signed [17:0] ax [3];
   logic signed [31:0] grav [3];
   logic signed [31:0] v3 [3];
   logic signed [31:0] v5 [3];
   logic signed [31:0] p7 [3];
   logic signed [31:0] acc_in [3];
   logic signed [31:0] nl_in;
   logic               live0;
   logic               live_in;
   logic signed [31:0] life_in;
   logic [3:0]         frame_in;
   logic signed [51:0] depth_sum;

   assign dts     = signed'({1'b0, cfg.step_time});
   assign ax[0]   = cfg.view_axis_x;
   assign ax[1]   = cfg.view_axis_y;
   assign ax[2]   = cfg.view_axis_z;
   assign grav[0] = 32'sd0;
   assign grav[1] = cfg.gravity_y;
   assign grav[2] = 32'sd0;

   assign v3[0] = rec_ff[2].velocity_x;
   assign v3[1] = rec_ff[2].velocity_y;
   assign v3[2] = rec_ff[2].velocity_z;
   assign v5[0] = rec_ff[4].velocity_x;
   assign v5[1] = rec_ff[4].velocity_y;
   assign v5[2] = rec_ff[4].velocity_z;
   assign p7[0] = rec_ff[6].position_x;
   assign p7[1] = rec_ff[6].position_y;
   assign p7[2] = rec_ff[6].position_z;

   assign en[10] = out_rdy;
   for (genvar k = 1; k <= 9; k++) begin : g_en
      assign en[k] = !vld_ff[k] || en[k+1];
   end
   assign in_rdy = en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[1]) vld_ff[1] <= in_vld;
         for (int k = 2; k <= 9; k++) begin
            if (en[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // drag opposes velocity; zero velocity has zero drag magnitude
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [48:0]        d;
         logic signed [50:0] a;
         d = 49'(hi2_ff[i]) + 49'(lo2_ff[i] >> 24);
         if (!v3[i][31] && (v3[i] != 32'sd0)) begin
            a = 51'(grav[i]) - signed'(51'(d));
         end else begin
            a = 51'(grav[i]) + signed'(51'(d));
         end
         acc_in[i] = sat32(64'(a));
      end
   end

   assign nl_in = sat32(64'(w1_ff.rec.life_left) - signed'(64'(dec1_ff[40:24])));

   always_comb begin
      live0    = rec_ff[7].alive && !np_ff[7][1][31];
      live_in  = live0 && !nl_ff[7][31] && (nl_ff[7] != 32'sd0);
      life_in  = live0 ? nl_ff[7] : rec_ff[7].life_left;
      frame_in = (live_in && rec_ff[7].advance_frame) ?
                 4'(rec_ff[7].frame_index + 4'd1) : rec_ff[7].frame_index;
   end

   assign depth_sum = 52'(dp8_ff[0]) + 52'(dp8_ff[1]) + 52'(dp8_ff[2]);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         w1_ff   <= in_work;
         dec1_ff <= in_work.rec.fade_rate * cfg.step_time;
         for (int i = 0; i < 3; i++) prod1_ff[i] <= in_work.mag[i] * in_speed;
      end
      if (en[2]) begin
         rec_ff[2] <= w1_ff.rec;
         nl_ff[2]  <= nl_in;
         for (int i = 0; i < 3; i++) begin
            hi2_ff[i] <= prod1_ff[i][63:40] * w1_ff.rec.drag_factor;
            lo2_ff[i] <= prod1_ff[i][39:16] * w1_ff.rec.drag_factor;
         end
      end
      for (int k = 3; k <= 7; k++) begin
         if (en[k]) begin
            rec_ff[k] <= rec_ff[k-1];
            nl_ff[k]  <= nl_ff[k-1];
         end
      end
      if (en[3]) begin
         for (int i = 0; i < 3; i++) acc3_ff[i] <= acc_in[i];
      end
      if (en[4]) begin
         for (int i = 0; i < 3; i++) adt4_ff[i] <= acc3_ff[i] * dts;
      end
      if (en[5]) begin
         for (int i = 0; i < 3; i++) begin
            nv_ff[5][i] <= sat32(64'(v5[i]) + 64'(adt4_ff[i] >>> 16));
         end
      end
      if (en[6]) begin
         nv_ff[6] <= nv_ff[5];
         for (int i = 0; i < 3; i++) vdt6_ff[i] <= nv_ff[5][i] * dts;
      end
      if (en[7]) begin
         nv_ff[7] <= nv_ff[6];
         for (int i = 0; i < 3; i++) begin
            np_ff[7][i] <= sat32(64'(p7[i]) + 64'(vdt6_ff[i] >>> 16));
         end
      end
      if (en[8]) begin
         nv_ff[8]  <= nv_ff[7];
         np_ff[8]  <= np_ff[7];
         life8_ff  <= life_in;
         live8_ff  <= live_in;
         frame8_ff <= frame_in;
         for (int i = 0; i < 3; i++) dp8_ff[i] <= np_ff[7][i] * ax[i];
      end
      if (en[9]) begin
         rsp9_ff.new_position_x  <= np_ff[8][0];
         rsp9_ff.new_position_y  <= np_ff[8][1];
         rsp9_ff.new_position_z  <= np_ff[8][2];
         rsp9_ff.new_velocity_x  <= nv_ff[8][0];
         rsp9_ff.new_velocity_y  <= nv_ff[8][1];
         rsp9_ff.new_velocity_z  <= nv_ff[8][2];
         rsp9_ff.new_life        <= life8_ff;
         rsp9_ff.still_alive     <= live8_ff;
         rsp9_ff.new_frame_index <= frame8_ff;
         rsp9_ff.view_depth      <= sat32(64'(depth_sum >>> 16));
      end
   end

   assign out_vld = vld_ff[9];
   assign out_rsp = rsp9_ff;
endmodule
`default_nettype wire

>>> design/particle_drag_euler_step.sv
`default_nettype none
`include "assert_macros.svh"
// Particle update: one Euler step with quadratic drag per beat, Q16.16 fixed
// point with saturation. A new beat is taken every cycle while the pipeline
// is not stalled. Each beat passes the squares and their sum, the speed
// square root at two root bits per stage, then drag, integration, life and
// view depth. rsp back-pressure stalls only the stages that hold data, so
// bubbles are squeezed out. The user must write registers through the APB
// port only while no beat is in flight; the block does not enforce this.
module particle_drag_euler_step (
   input  wire logic                         clock,
   input  wire logic                         reset,
   pdes_req_if.sink                          req_bus,
   pdes_rsp_if.source                        rsp_bus,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [pdes_pkg::CSR_AW-1:0]  paddr,
   input  wire logic [31:0]                  pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import pdes_pkg::*;

   cfg_type     cfg;
   logic        fr_vld;
   logic        fr_rdy;
   work_type    fr_work;
   logic [63:0] fr_sumsq;
   logic        sq_vld;
   logic        sq_rdy;
   work_type    sq_work;
   logic [31:0] sq_root;
   logic        req_rdy;
   logic        rsp_vld;
   rsp_type     rsp_data;

   pdes_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pdes_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_vld    (req_bus.valid),
      .in_rec    (req_bus.data),
      .in_rdy    (req_rdy),
      .out_vld   (fr_vld),
      .out_work  (fr_work),
      .out_sumsq (fr_sumsq),
      .out_rdy   (fr_rdy)
   );

   pdes_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (fr_vld),
      .in_work  (fr_work),
      .in_rad   (fr_sumsq),
      .in_rdy   (fr_rdy),
      .out_vld  (sq_vld),
      .out_work (sq_work),
      .out_root (sq_root),
      .out_rdy  (sq_rdy)
   );

   pdes_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (sq_vld),
      .in_work  (sq_work),
      .in_speed (sq_root),
      .in_rdy   (sq_rdy),
      .cfg      (cfg),
      .out_vld  (rsp_vld),
      .out_rsp  (rsp_data),
      .out_rdy  (rsp_bus.ready)
   );

   assign req_bus.ready = req_rdy;
   assign rsp_bus.valid = rsp_vld;
   assign rsp_bus.data  = rsp_data;

   `PDES_ASSERT_NOW(a_alive_above_ground, !(rsp_vld && rsp_data.still_alive) || !rsp_data.new_position_y[31])
   `PDES_ASSERT_NOW(a_alive_has_life, !(rsp_vld && rsp_data.still_alive) || (!rsp_data.new_life[31] && rsp_data.new_life != 32'sd0))
   `PDES_ASSERT_NEXT(a_step_write, psel && penable && pwrite && paddr[CSR_AW-1:2] == REG_STEP_TIME, cfg.step_time == $past(pwdata[16:0]))
endmodule
`default_nettype wire
